/* rtl/tfzs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tfzs_pkg;

   localparam int BufferBytes = 65536;
   localparam int PosWidth    = 17;

   localparam logic [7:0] SohByte   = 8'h01;
   localparam logic [7:0] SixChar   = 8'h36;
   localparam logic [7:0] SevenChar = 8'h37;
   localparam logic [7:0] EqualChar = 8'h3D;

   localparam logic [2:0] StFound    = 3'd0;
   localparam logic [2:0] StNoStart  = 3'd1;
   localparam logic [2:0] StBadStart = 3'd2;
   localparam logic [2:0] StNoEnd    = 3'd3;
   localparam logic [2:0] StBadEnd   = 3'd4;
   localparam logic [2:0] StMismatch = 3'd5;

   // The phase codes of the active phases double as the status of a range that ends early.
   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_SEEK_START  = 3'd1,
      PH_START_VALUE = 3'd2,
      PH_SEEK_END    = 3'd3,
      PH_END_VALUE   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      NS_SPACE,
      NS_SIGN,
      NS_ZERO,
      NS_PREFIX,
      NS_DIGITS
   } num_sub_type;

   typedef enum logic [1:0] {
      FEED_MORE,
      FEED_OK,
      FEED_BAD
   } feed_type;

   typedef struct packed {
      num_sub_type sub;
      logic        negative;
      logic [63:0] magnitude;
      logic        zero_end;
   } num_state_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] field_id;
      logic [15:0] zone_start;
      logic [16:0] zone_end;
   } result_type;

   localparam num_state_type NumReset = '{sub: NS_SPACE, negative: 1'b0,
                                          magnitude: 64'd0, zero_end: 1'b0};

endpackage

`default_nettype wire

/* rtl/tfzs_hex_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfzs_hex_parser (
   input  tfzs_pkg::num_state_type num_cur,
   input  logic [7:0]              data_byte,
   output tfzs_pkg::num_state_type num_next,
   output tfzs_pkg::feed_type      feed,
   output logic [15:0]             low_bits
);
   import tfzs_pkg::*;

   logic        is_digit;
   logic [3:0]  digit;
   logic [67:0] grown;
   logic        fits;

   always_comb begin
      is_digit = 1'b1;
      digit    = 4'd0;
      if (data_byte inside {[8'h30:8'h39]}) begin
         digit = 4'(data_byte - 8'h30);
      end else if (data_byte inside {[8'h61:8'h66]}) begin
         digit = 4'(data_byte - 8'h57);
      end else if (data_byte inside {[8'h41:8'h46]}) begin
         digit = 4'(data_byte - 8'h37);
      end else begin
         is_digit = 1'b0;
      end
   end

   // The magnitude may reach 2^63 only for a negative value.
   assign grown = {num_cur.magnitude, 4'h0} + {64'd0, digit};
   assign fits  = (grown[67:64] == 4'd0) &&
                  (!grown[63] || (num_cur.negative && (grown[62:0] == 63'd0)));

   assign low_bits = num_cur.negative ? 16'(16'd0 - num_cur.magnitude[15:0])
                                      : num_cur.magnitude[15:0];

   always_comb begin
      num_next = num_cur;
      feed     = FEED_MORE;
      if (num_cur.zero_end) begin
         feed = (data_byte == SohByte) ? FEED_OK : FEED_MORE;
      end else begin
         case (num_cur.sub)
            NS_SPACE: begin
               if (data_byte inside {8'h20, [8'h09:8'h0D]}) begin
                  feed = FEED_MORE;
               end else if (data_byte inside {8'h2B, 8'h2D}) begin
                  num_next.negative = (data_byte == 8'h2D);
                  num_next.sub      = NS_SIGN;
               end else if (data_byte == 8'h30) begin
                  num_next.sub = NS_ZERO;
               end else if (is_digit && fits) begin
                  num_next.magnitude = grown[63:0];
                  num_next.sub       = NS_DIGITS;
               end else begin
                  feed = FEED_BAD;
               end
            end
            NS_SIGN: begin
               if (data_byte == 8'h30) begin
                  num_next.sub = NS_ZERO;
               end else if (is_digit && fits) begin
                  num_next.magnitude = grown[63:0];
                  num_next.sub       = NS_DIGITS;
               end else begin
                  feed = FEED_BAD;
               end
            end
            NS_ZERO: begin
               if (data_byte inside {8'h78, 8'h58}) begin
                  num_next.sub = NS_PREFIX;
               end else if (is_digit) begin
                  if (fits) begin
                     num_next.magnitude = grown[63:0];
                     num_next.sub       = NS_DIGITS;
                  end else begin
                     feed = FEED_BAD;
                  end
               end else if (data_byte == 8'h00) begin
                  num_next.zero_end = 1'b1;
               end else if (data_byte == SohByte) begin
                  feed = FEED_OK;
               end else begin
                  feed = FEED_BAD;
               end
            end
            NS_PREFIX: begin
               if (is_digit && fits) begin
                  num_next.magnitude = grown[63:0];
                  num_next.sub       = NS_DIGITS;
               end else begin
                  feed = FEED_BAD;
               end
            end
            NS_DIGITS: begin
               if (is_digit) begin
                  if (fits) begin
                     num_next.magnitude = grown[63:0];
                  end else begin
                     feed = FEED_BAD;
                  end
               end else if (data_byte == 8'h00) begin
                  num_next.zero_end = 1'b1;
               end else if (data_byte == SohByte) begin
                  feed = FEED_OK;
               end else begin
                  feed = FEED_BAD;
               end
            end
            default: begin
               feed = FEED_BAD;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/tagged_field_zone_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none

// Scans a byte stream for a field zone opened by SOH 6= id SOH and closed by SOH 7= id SOH.
// Each request carries one byte. The tuser bit starts a new scan at that byte, and tlast
// marks the final byte of the scan range. A scan ends in exactly one result with a status,
// the zone id and the zone's start and end positions.
// A request is accepted whenever the two-entry result queue has room, so one byte per cycle
// is sustained while results are taken; the byte state is updated in the cycle of acceptance.
// A result is registered as its final byte is accepted; it waits behind older results.
// When the receiver stalls, results wait in the queue, and requests stall only once both
// entries are full. Reset leaves the scanner idle with an empty queue; bytes that arrive
// while idle without the start flag are dropped.
module tagged_field_zone_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // data_byte [7:0], start_offset [23:8], before_is_soh [24], zeros above.
   input  wire logic [31:0] req_tdata,
   // first_byte.
   input  wire logic        req_tuser,
   // last_byte.
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status [2:0], field_id [18:3], zone_start [34:19], zone_end [51:35], zeros above.
   output logic [55:0]      rsp_tdata
);
   import tfzs_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [7:0]            prev_ff, prev_in;
   logic                  prev_valid_ff, prev_valid_in;
   logic                  bb_soh_ff, bb_soh_in;
   num_state_type         num_ff, num_in;
   logic [15:0]           open_id_ff, open_id_in;
   logic [15:0]           open_pos_ff, open_pos_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;

   result_type            queue_ff [2];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            count_ff;

   logic                  accept, pop, push;
   logic [7:0]            data_byte;
   logic [15:0]           start_offset;
   logic                  lead_soh;
   phase_type             phase_w;
   logic [PosWidth-1:0]   pos_w;
   logic                  prev_valid_w;
   num_state_type         num_w, num_parsed;
   feed_type              feed;
   logic [15:0]           low_bits;
   logic                  mark_open, mark_close, done;
   result_type            res;
   result_type            head;

   assign data_byte    = req_tdata[7:0];
   assign start_offset = req_tdata[23:8];
   assign lead_soh     = req_tdata[24] && (start_offset != 16'd0);

   assign req_tready = (count_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign phase_w      = req_tuser ? PH_SEEK_START : phase_ff;
   assign pos_w        = req_tuser ? PosWidth'(start_offset) : PosWidth'(pos_ff + 1'b1);
   assign prev_valid_w = req_tuser ? 1'b0 : prev_valid_ff;
   assign num_w        = req_tuser ? NumReset : num_ff;

   assign mark_open  = prev_valid_w && bb_soh_ff && (prev_ff == SixChar) &&
                       (data_byte == EqualChar);
   assign mark_close = prev_valid_w && bb_soh_ff && (prev_ff == SevenChar) &&
                       (data_byte == EqualChar);

   tfzs_hex_parser u_parser (
      .num_cur   (num_w),
      .data_byte (data_byte),
      .num_next  (num_parsed),
      .feed      (feed),
      .low_bits  (low_bits)
   );

   always_comb begin
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      bb_soh_in     = bb_soh_ff;
      num_in        = num_ff;
      open_id_in    = open_id_ff;
      open_pos_in   = open_pos_ff;
      pos_in        = pos_ff;
      push          = 1'b0;
      done          = 1'b0;
      res           = '0;
      if (accept && (req_tuser || (phase_ff != PH_IDLE))) begin
         phase_in      = phase_w;
         pos_in        = pos_w;
         num_in        = num_w;
         bb_soh_in     = prev_valid_w ? (prev_ff == SohByte) : lead_soh;
         prev_in       = data_byte;
         prev_valid_in = 1'b1;
         case (phase_w)
            PH_SEEK_START: begin
               if (mark_open) begin
                  open_pos_in = 16'(pos_w - 1'b1);
                  num_in      = NumReset;
                  phase_in    = PH_START_VALUE;
               end
            end
            PH_START_VALUE: begin
               num_in = num_parsed;
               if (feed == FEED_OK) begin
                  open_id_in = low_bits;
                  phase_in   = PH_SEEK_END;
               end else if (feed == FEED_BAD) begin
                  res.status = StBadStart;
                  push       = 1'b1;
                  done       = 1'b1;
                  phase_in   = PH_IDLE;
               end
            end
            PH_SEEK_END: begin
               if (mark_close) begin
                  num_in   = NumReset;
                  phase_in = PH_END_VALUE;
               end
            end
            PH_END_VALUE: begin
               num_in = num_parsed;
               if (feed == FEED_OK) begin
                  res.status     = (low_bits == open_id_ff) ? StFound : StMismatch;
                  res.field_id   = open_id_ff;
                  res.zone_start = open_pos_ff;
                  res.zone_end   = 17'(pos_w + 1'b1);
                  push           = 1'b1;
                  done           = 1'b1;
                  phase_in       = PH_IDLE;
               end else if (feed == FEED_BAD) begin
                  res.status     = StBadEnd;
                  res.field_id   = open_id_ff;
                  res.zone_start = open_pos_ff;
                  push           = 1'b1;
                  done           = 1'b1;
                  phase_in       = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         endcase
         if (!done && (req_tlast || (pos_w >= PosWidth'(BufferBytes - 1)))) begin
            res.status = 3'(phase_in);
            if ((phase_in == PH_SEEK_END) || (phase_in == PH_END_VALUE)) begin
               res.field_id   = open_id_in;
               res.zone_start = open_pos_in;
            end
            push     = 1'b1;
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prev_valid_ff <= 1'b0;
         num_ff        <= NumReset;
      end else begin
         phase_ff      <= phase_in;
         prev_valid_ff <= prev_valid_in;
         num_ff        <= num_in;
      end
      prev_ff     <= prev_in;
      bb_soh_ff   <= bb_soh_in;
      open_id_ff  <= open_id_in;
      open_pos_ff <= open_pos_in;
      pos_ff      <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= 2'(count_ff + {1'b0, push} - {1'b0, pop});
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= res;
      end
   end

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {4'd0, head.zone_end, head.zone_start, head.field_id, head.status};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue count out of range");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= StMismatch))
      else $error("result status out of range");

   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast && (req_tuser || (phase_ff != PH_IDLE)) && !pop)
      |=> (count_ff == 2'($past(count_ff) + 2'd1)))
      else $error("final byte of an active scan gave no result");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (phase_ff == PH_IDLE))
      else $error("scan still active after final byte");

endmodule

`default_nettype wire
